[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TEAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TEAF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/teaf_pkg.sv]
// ----------------------------------------------------------------------------
// teaf_pkg
// Types, constants and helpers for the temporal edge activity filter.
// ----------------------------------------------------------------------------
package teaf_pkg;

  // Width of the rebuilt change times; the running sum wraps at this width.
  localparam int TIME_BITS = 32;

  localparam int WORD_W     = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MODE   = 2'd2;

  // Query modes
  localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WEAK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STRONG = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd3;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [WORD_W-1:0] window_start;
    logic [WORD_W-1:0] window_end;
    logic [MODE_W-1:0] query_mode;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] neighbor_id;
    logic [WORD_W-1:0] time_delta;
    logic              first_in_list;
    logic              last_in_list;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] active_neighbor;
    logic [WORD_W-1:0] next_time;
    logic              no_next;
  } res_t;

  // 32-bit field to time width (truncate or zero-extend)
  function automatic time_t to_time(input logic [WORD_W-1:0] v);
    logic [TIME_BITS+WORD_W-1:0] ext;
    ext = {{TIME_BITS{1'b0}}, v};
    return ext[TIME_BITS-1:0];
  endfunction

  // time width back to a 32-bit field
  function automatic logic [WORD_W-1:0] to_word(input time_t t);
    logic [TIME_BITS+WORD_W-1:0] ext;
    ext = {{WORD_W{1'b0}}, t};
    return ext[WORD_W-1:0];
  endfunction

endpackage

[src/teaf_if.sv]
// ----------------------------------------------------------------------------
// teaf_if
// Valid/ready stream interfaces for the list items and the result beats.
// ----------------------------------------------------------------------------
interface teaf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] neighbor_id;
  logic [31:0] time_delta;
  logic        first_in_list;
  logic        last_in_list;

  modport source (output valid, output neighbor_id, output time_delta,
                  output first_in_list, output last_in_list, input ready);
  modport sink   (input valid, input neighbor_id, input time_delta,
                  input first_in_list, input last_in_list, output ready);
endinterface

interface teaf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] active_neighbor;
  logic [31:0] next_time;
  logic        no_next;

  modport source (output valid, output active_neighbor, output next_time,
                  output no_next, input ready);
  modport sink   (input valid, input active_neighbor, input next_time,
                  input no_next, output ready);
endinterface

[src/teaf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// teaf_cfg_regs
// Query window and mode registers, written through the plain write port.
// ----------------------------------------------------------------------------
module teaf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [teaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [teaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output teaf_pkg::cfg_t                 cfg
);
  import teaf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_START: cfg_nxt.window_start = cfg_wdata[WORD_W-1:0];
        CFG_WINDOW_END:   cfg_nxt.window_end   = cfg_wdata[WORD_W-1:0];
        CFG_QUERY_MODE:   cfg_nxt.query_mode   = cfg_wdata[MODE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/teaf_list_tracker.sv]
// ----------------------------------------------------------------------------
// teaf_list_tracker
// Per-list state: running time, parity before start, window hit and the
// first later change. Decides the result on the last item of a list.
// ----------------------------------------------------------------------------
module teaf_list_tracker (
  input  logic            clk,
  input  logic            rst_n,
  input  teaf_pkg::cfg_t  cfg,
  input  teaf_pkg::item_t item,
  input  logic            step,   // item leaves the input register this cycle
  output logic            emit,   // item is last and satisfies the query
  output teaf_pkg::res_t  res
);
  import teaf_pkg::*;

  time_t running_r,  running_nxt;
  logic  odd_r,      odd_nxt;
  logic  in_win_r,   in_win_nxt;
  time_t later_r,    later_nxt;
  logic  found_r,    found_nxt;

  time_t s, e, delta, now;
  time_t base_t, base_later;
  logic  base_odd, base_in_win, base_found;
  logic  le_start;
  logic  upd_odd, upd_in_win, upd_found;
  time_t upd_later;
  logic  hit, none;
  time_t nt;

  always_comb begin
    s     = to_time(cfg.window_start);
    e     = to_time(cfg.window_end);
    delta = to_time(item.time_delta);

    // a first mark restarts the list
    base_t      = item.first_in_list ? '0   : running_r;
    base_odd    = item.first_in_list ? 1'b0 : odd_r;
    base_in_win = item.first_in_list ? 1'b0 : in_win_r;
    base_later  = item.first_in_list ? '0   : later_r;
    base_found  = item.first_in_list ? 1'b0 : found_r;

    now      = base_t + delta;
    le_start = (now <= s);

    upd_odd    = base_odd ^ le_start;
    upd_in_win = base_in_win | (!le_start && (now <= e));
    upd_found  = base_found | !le_start;
    upd_later  = (!le_start && !base_found) ? now : base_later;

    hit  = 1'b0;
    none = 1'b0;
    nt   = '0;
    case (cfg.query_mode)
      MODE_POINT:  hit = upd_odd;
      MODE_WEAK:   hit = upd_odd | upd_in_win;
      MODE_STRONG: hit = upd_odd & !upd_in_win;
      MODE_NEXT: begin
        hit = 1'b1;
        if (upd_odd) begin
          nt = s;
        end else if (upd_found) begin
          nt = upd_later;
        end else if (now == s) begin
          nt = s;
        end else begin
          none = 1'b1;
        end
      end
      default: hit = 1'b0;
    endcase

    emit                = item.last_in_list & hit;
    res.active_neighbor = item.neighbor_id;
    res.next_time       = to_word(nt);
    res.no_next         = none;

    running_nxt = running_r;
    odd_nxt     = odd_r;
    in_win_nxt  = in_win_r;
    later_nxt   = later_r;
    found_nxt   = found_r;
    if (step) begin
      if (item.last_in_list) begin
        // list closes: state clears for whatever follows
        running_nxt = '0;
        odd_nxt     = 1'b0;
        in_win_nxt  = 1'b0;
        later_nxt   = '0;
        found_nxt   = 1'b0;
      end else begin
        running_nxt = now;
        odd_nxt     = upd_odd;
        in_win_nxt  = upd_in_win;
        later_nxt   = upd_later;
        found_nxt   = upd_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      odd_r     <= 1'b0;
      in_win_r  <= 1'b0;
      later_r   <= '0;
      found_r   <= 1'b0;
    end else begin
      running_r <= running_nxt;
      odd_r     <= odd_nxt;
      in_win_r  <= in_win_nxt;
      later_r   <= later_nxt;
      found_r   <= found_nxt;
    end
  end

endmodule

[src/teaf_out_reg.sv]
// ----------------------------------------------------------------------------
// teaf_out_reg
// Result register driving the output stream.
// ----------------------------------------------------------------------------
module teaf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  teaf_pkg::res_t    res,
  output logic              free,   // can take a beat this cycle
  teaf_out_if.source        out_ch
);
  import teaf_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r,  data_nxt;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.active_neighbor = data_r.active_neighbor;
  assign out_ch.next_time       = data_r.next_time;
  assign out_ch.no_next         = data_r.no_next;

endmodule

[src/temporal_edge_activity_filter_unit.sv]
// ----------------------------------------------------------------------------
// temporal_edge_activity_filter_unit
// Streams a node's neighbor change lists and emits the neighbors that match
// the configured time query.
//
// in_ch carries one delta-coded change time per beat, with first/last list
// marks; out_ch carries at most one result beat per list, on its last item.
// cfg_we/cfg_index/cfg_wdata write window_start (0), window_end (1) and
// query_mode (2); other indexes are dropped. Write only while idle.
// Throughput: one item per cycle while the output register can take results.
// An accepted item passes two registers (input, result) before its result
// is on out_ch. The time add and compares sit in the single stage between them.
// Reset (rst_n low, synchronous) clears the config, list state and both
// valid flags. When out_ch stalls with a result held, items that give no
// result still drain; a result-bearing item waits in the input register and
// in_ch.ready drops until the output register frees up.
// ----------------------------------------------------------------------------
module temporal_edge_activity_filter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [teaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [teaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  teaf_in_if.sink                         in_ch,
  teaf_out_if.source                      out_ch
);
  import teaf_pkg::*;

  cfg_t  cfg;
  item_t item_r, item_nxt;
  logic  valid_r, valid_nxt;
  logic  emit, out_free, advance, in_fire;
  res_t  res;

  assign advance      = valid_r && (!emit || out_free);
  assign in_ch.ready  = !valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_fire) begin
      valid_nxt              = 1'b1;
      item_nxt.neighbor_id   = in_ch.neighbor_id;
      item_nxt.time_delta    = in_ch.time_delta;
      item_nxt.first_in_list = in_ch.first_in_list;
      item_nxt.last_in_list  = in_ch.last_in_list;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  teaf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  teaf_list_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .step  (advance),
    .emit  (emit),
    .res   (res)
  );

  teaf_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance && emit),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

[src/teaf_checker.sv]
// ----------------------------------------------------------------------------
// teaf_checker
// Port-level checks on the filter unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module teaf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_in_list,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_time,
  input logic        out_no_next
);

  logic in_last_fire;

  assign in_last_fire = in_valid && in_ready && in_last_in_list;

  // held result beat stays up until taken
  `TEAF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

  // no next activation carries a zero time
  `TEAF_ASSERT(a_no_next_zero, out_valid && out_no_next |-> out_next_time == '0, "bad time")

  // a fresh result traces back to an accepted last item
  `TEAF_ASSERT(a_rise_from_last, $rose(out_valid) |-> $past(in_last_fire, 2), "orphan result")

  // reset empties the result register
  `TEAF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind temporal_edge_activity_filter_unit teaf_checker u_teaf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_in_list (in_ch.last_in_list),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_next_time   (out_ch.next_time),
  .out_no_next     (out_ch.no_next)
);
